// ===== design/mbtrs_pkg.sv =====
// Shared constants and types for the Modbus TCP holding register server.
// Used by the controller and the top level; depends on nothing else.
package mbtrs_pkg;

  localparam logic [1:0] CMD_NET_BYTE    = 2'd0;
  localparam logic [1:0] CMD_LOCAL_WRITE = 2'd1;
  localparam logic [1:0] CMD_LOCAL_READ  = 2'd2;

  localparam logic KIND_NET   = 1'b0;
  localparam logic KIND_LOCAL = 1'b1;

  localparam logic CFG_INPUT_COUNT  = 1'b0;
  localparam logic CFG_OUTPUT_COUNT = 1'b1;

  localparam logic [7:0] FUNC_READ_HOLDING  = 8'd3;
  localparam logic [7:0] FUNC_WRITE_MULTIPLE = 8'd16;

  localparam logic [8:0] MIN_FRAME_LEN  = 9'd12;
  localparam logic [8:0] BYTE_COUNT_MAX = 9'd256;
  localparam logic [7:0] ECHO_LENGTH    = 8'd6;
  localparam logic [3:0] READ_HDR_LAST  = 4'd8;
  localparam logic [3:0] ECHO_LAST      = 4'd11;
  localparam int         HDR_BYTES      = 12;
  localparam int         WRITE_DATA_START = 13;
  localparam logic [3:0] COUNT_RESET    = 4'd4;

  typedef struct packed {
    logic [3:0] input_count;
    logic [3:0] output_count;
  } cfg_t;

endpackage

// ===== design/mbtrs_frame_mem.sv =====
// Request frame buffer: one write port, one read port with registered data.
// Standalone; no package needed.
module mbtrs_frame_mem #(
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== design/mbtrs_table_mem.sv =====
// Holding register table: one write port, one registered read port.
// Per-entry valid bits make the whole table read as zero after reset.
module mbtrs_table_mem #(
  parameter int DEPTH = 8,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [15:0]   wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [15:0]   rd_data
);

  logic [15:0]      mem [DEPTH];
  logic [DEPTH-1:0] valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= valid[rd_addr] ? mem[rd_addr] : 16'd0;
  end

endmodule

// ===== design/mbtrs_ctrl.sv =====
// Request sequencer: collects bytes, checks the frame, runs the register
// table and frame buffer ports and drives the response register. Uses mbtrs_pkg.
module mbtrs_ctrl #(
  parameter int REGISTERS   = 8,
  parameter int FRAME_BYTES = 32,
  localparam int TW = $clog2(REGISTERS),
  localparam int FW = $clog2(FRAME_BYTES)
) (
  input  logic               clk,
  input  logic               rst,
  input  mbtrs_pkg::cfg_t    cfg,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic [1:0]         cmd,
  input  logic [7:0]         rx_byte,
  input  logic               segment_end,
  input  logic [2:0]         local_index,
  input  logic signed [15:0] local_value,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output logic               kind,
  output logic [7:0]         tx_byte,
  output logic signed [15:0] read_value,
  output logic               last,
  output logic               frame_wr_en,
  output logic [FW-1:0]      frame_wr_addr,
  output logic [7:0]         frame_wr_data,
  output logic [FW-1:0]      frame_rd_addr,
  input  logic [7:0]         frame_rd_data,
  output logic               tbl_wr_en,
  output logic [TW-1:0]      tbl_wr_addr,
  output logic [15:0]        tbl_wr_data,
  output logic [TW-1:0]      tbl_rd_addr,
  input  logic [15:0]        tbl_rd_data
);
  import mbtrs_pkg::*;

  localparam int QW = $clog2(REGISTERS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_RHDR, S_RDATA, S_WFETCH, S_WHI, S_WLO, S_ECHO, S_LWAIT, S_LEMIT
  } state_t;

  state_t        state;
  logic [8:0]    byte_count;
  logic [7:0]    hdr [HDR_BYTES];
  logic [3:0]    hdr_cnt;
  logic [QW-1:0] quant_r;
  logic [QW-1:0] reg_cnt;
  logic          lo_phase;
  logic [TW-1:0] tbl_ptr;
  logic [FW-1:0] frame_ptr;
  logic [7:0]    hold_byte;
  logic          lread_ok;

  logic        req_fire;
  logic        out_free;
  logic        rsp_load;
  logic [8:0]  count_inc;
  logic [4:0]  idx5;
  logic [4:0]  pos5;
  logic [4:0]  sum5;
  logic [4:0]  served5;
  logic        lwrite_ok;
  logic        lread_hit;
  logic [15:0] start;
  logic [15:0] quant;
  logic [16:0] span;
  logic [17:0] need;
  logic        hdr_ok;
  logic        range_ok;
  logic        write_fits;
  logic        go_read;
  logic        go_write;
  logic        last_reg;
  logic [15:0] plen;
  logic [7:0]  rhdr_byte;
  logic [7:0]  echo_byte;

  assign req_ready = (state == S_IDLE);
  assign req_fire  = req_valid && req_ready;
  assign out_free  = !rsp_valid || rsp_ready;
  assign rsp_load  = out_free && ((state == S_RHDR) || (state == S_RDATA) ||
                                  (state == S_ECHO) || (state == S_LEMIT));
  assign count_inc = (byte_count == BYTE_COUNT_MAX) ? byte_count : byte_count + 9'd1;

  assign idx5      = {2'b00, local_index};
  assign pos5      = {1'b0, cfg.input_count} + idx5;
  assign sum5      = {1'b0, cfg.input_count} + {1'b0, cfg.output_count};
  assign served5   = (sum5 > 5'(REGISTERS)) ? 5'(REGISTERS) : sum5;
  assign lwrite_ok = (idx5 < {1'b0, cfg.input_count}) && (idx5 < 5'(REGISTERS));
  assign lread_hit = (idx5 < {1'b0, cfg.output_count}) && (pos5 < served5);

  assign start      = {hdr[8], hdr[9]};
  assign quant      = {hdr[10], hdr[11]};
  assign span       = {1'b0, start} + {1'b0, quant};
  assign need       = 18'(WRITE_DATA_START) + {1'b0, quant, 1'b0};
  assign hdr_ok     = (byte_count >= MIN_FRAME_LEN) && (hdr[2] == 8'd0) && (hdr[3] == 8'd0);
  assign range_ok   = (quant != 16'd0) && (span <= {12'd0, served5});
  assign write_fits = (need <= {9'd0, byte_count}) && (need <= 18'(FRAME_BYTES));
  assign go_read    = hdr_ok && range_ok && (hdr[7] == FUNC_READ_HOLDING);
  assign go_write   = hdr_ok && range_ok && (hdr[7] == FUNC_WRITE_MULTIPLE) && write_fits;
  assign last_reg   = (reg_cnt + QW'(1)) == quant_r;
  assign plen       = 16'd3 + {15'(quant_r), 1'b0};

  assign frame_wr_en   = req_fire && (cmd == CMD_NET_BYTE) && (byte_count < 9'(FRAME_BYTES));
  assign frame_wr_addr = byte_count[FW-1:0];
  assign frame_wr_data = rx_byte;
  assign frame_rd_addr = frame_ptr;
  assign tbl_rd_addr   = tbl_ptr;

  always_comb begin
    if (state == S_WLO) begin
      tbl_wr_en   = 1'b1;
      tbl_wr_addr = tbl_ptr;
      tbl_wr_data = {hold_byte, frame_rd_data};
    end else begin
      tbl_wr_en   = req_fire && (cmd == CMD_LOCAL_WRITE) && lwrite_ok;
      tbl_wr_addr = TW'(local_index);
      tbl_wr_data = local_value;
    end
  end

  always_comb begin
    case (hdr_cnt)
      4'd4:    rhdr_byte = plen[15:8];
      4'd5:    rhdr_byte = plen[7:0];
      4'd6:    rhdr_byte = hdr[6];
      4'd7:    rhdr_byte = FUNC_READ_HOLDING;
      4'd8:    rhdr_byte = plen[7:0] - 8'd3;
      default: rhdr_byte = hdr[hdr_cnt];
    endcase
  end

  always_comb begin
    case (hdr_cnt)
      4'd4:    echo_byte = 8'd0;
      4'd5:    echo_byte = ECHO_LENGTH;
      default: echo_byte = hdr[hdr_cnt];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      byte_count <= 9'd0;
      hdr_cnt    <= 4'd0;
      quant_r    <= '0;
      reg_cnt    <= '0;
      lo_phase   <= 1'b0;
      tbl_ptr    <= '0;
      frame_ptr  <= '0;
      lread_ok   <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_fire) begin
            case (cmd)
              CMD_NET_BYTE: begin
                if (byte_count < MIN_FRAME_LEN) begin
                  hdr[byte_count[3:0]] <= rx_byte;
                end
                byte_count <= count_inc;
                if (segment_end) begin
                  state <= S_CHECK;
                end
              end
              CMD_LOCAL_READ: begin
                tbl_ptr  <= lread_hit ? TW'(pos5) : '0;
                lread_ok <= lread_hit;
                state    <= S_LWAIT;
              end
              default: ;
            endcase
          end
        end
        S_CHECK: begin
          hdr_cnt   <= 4'd0;
          reg_cnt   <= '0;
          lo_phase  <= 1'b0;
          quant_r   <= QW'(quant);
          tbl_ptr   <= TW'(start);
          frame_ptr <= FW'(WRITE_DATA_START);
          if (go_read) begin
            state <= S_RHDR;
          end else if (go_write) begin
            state <= S_WFETCH;
          end else begin
            state      <= S_IDLE;
            byte_count <= 9'd0;
          end
        end
        S_RHDR: begin
          if (out_free) begin
            kind       <= KIND_NET;
            tx_byte    <= rhdr_byte;
            read_value <= 16'sd0;
            last       <= 1'b0;
            if (hdr_cnt == READ_HDR_LAST) begin
              state <= S_RDATA;
            end else begin
              hdr_cnt <= hdr_cnt + 4'd1;
            end
          end
        end
        S_RDATA: begin
          if (out_free) begin
            kind       <= KIND_NET;
            read_value <= 16'sd0;
            if (!lo_phase) begin
              tx_byte   <= tbl_rd_data[15:8];
              hold_byte <= tbl_rd_data[7:0];
              last      <= 1'b0;
              lo_phase  <= 1'b1;
              if (!last_reg) begin
                tbl_ptr <= tbl_ptr + TW'(1);
              end
            end else begin
              tx_byte  <= hold_byte;
              last     <= last_reg;
              lo_phase <= 1'b0;
              if (last_reg) begin
                state      <= S_IDLE;
                byte_count <= 9'd0;
              end else begin
                reg_cnt <= reg_cnt + QW'(1);
              end
            end
          end
        end
        S_WFETCH: begin
          frame_ptr <= frame_ptr + FW'(1);
          state     <= S_WHI;
        end
        S_WHI: begin
          hold_byte <= frame_rd_data;
          if (!last_reg) begin
            frame_ptr <= frame_ptr + FW'(1);
          end
          state <= S_WLO;
        end
        S_WLO: begin
          if (last_reg) begin
            hdr_cnt <= 4'd0;
            state   <= S_ECHO;
          end else begin
            reg_cnt   <= reg_cnt + QW'(1);
            tbl_ptr   <= tbl_ptr + TW'(1);
            frame_ptr <= frame_ptr + FW'(1);
            state     <= S_WHI;
          end
        end
        S_ECHO: begin
          if (out_free) begin
            kind       <= KIND_NET;
            tx_byte    <= echo_byte;
            read_value <= 16'sd0;
            last       <= (hdr_cnt == ECHO_LAST);
            if (hdr_cnt == ECHO_LAST) begin
              state      <= S_IDLE;
              byte_count <= 9'd0;
            end else begin
              hdr_cnt <= hdr_cnt + 4'd1;
            end
          end
        end
        S_LWAIT: begin
          state <= S_LEMIT;
        end
        S_LEMIT: begin
          if (out_free) begin
            kind       <= KIND_LOCAL;
            tx_byte    <= 8'd0;
            read_value <= lread_ok ? $signed(tbl_rd_data) : 16'sd0;
            last       <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/modbus_tcp_register_server.sv =====
// Modbus TCP holding register server, top level: configuration registers and
// the instances of mbtrs_ctrl, mbtrs_frame_mem and mbtrs_table_mem. Uses mbtrs_pkg.
//
// Request bytes are taken at one per cycle while the sequencer is idle. The
// last byte of a segment is followed by a check state, after which a read
// request (function 3) sends 9 header bytes at one per cycle, while the
// output is not stalled, and then two bytes per register, and a write request
// (function 16) copies its data through the single read port of the frame
// buffer before sending its 12-byte echo. A local write is done in the idle
// state; a local read waits in S_LWAIT for the registered read of the table
// and emits in S_LEMIT. No new item is taken until the current one has handed
// its last result to the output register; output stalls hold the sequencer.
// Reset clears the register table at once through per-entry valid bits.
module modbus_tcp_register_server #(
  parameter int REGISTERS   = 8,
  parameter int FRAME_BYTES = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [3:0]         cfg_data,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic [1:0]         cmd,
  input  logic [7:0]         rx_byte,
  input  logic               segment_end,
  input  logic [2:0]         local_index,
  input  logic signed [15:0] local_value,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output logic               kind,
  output logic [7:0]         tx_byte,
  output logic signed [15:0] read_value,
  output logic               last
);
  import mbtrs_pkg::*;

  localparam int TW = $clog2(REGISTERS);
  localparam int FW = $clog2(FRAME_BYTES);

  cfg_t          cfg;
  logic          frame_wr_en;
  logic [FW-1:0] frame_wr_addr;
  logic [7:0]    frame_wr_data;
  logic [FW-1:0] frame_rd_addr;
  logic [7:0]    frame_rd_data;
  logic          tbl_wr_en;
  logic [TW-1:0] tbl_wr_addr;
  logic [15:0]   tbl_wr_data;
  logic [TW-1:0] tbl_rd_addr;
  logic [15:0]   tbl_rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.input_count  <= COUNT_RESET;
      cfg.output_count <= COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_INPUT_COUNT:  cfg.input_count  <= cfg_data;
        CFG_OUTPUT_COUNT: cfg.output_count <= cfg_data;
        default: ;
      endcase
    end
  end

  mbtrs_ctrl #(
    .REGISTERS   (REGISTERS),
    .FRAME_BYTES (FRAME_BYTES)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .cmd           (cmd),
    .rx_byte       (rx_byte),
    .segment_end   (segment_end),
    .local_index   (local_index),
    .local_value   (local_value),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .kind          (kind),
    .tx_byte       (tx_byte),
    .read_value    (read_value),
    .last          (last),
    .frame_wr_en   (frame_wr_en),
    .frame_wr_addr (frame_wr_addr),
    .frame_wr_data (frame_wr_data),
    .frame_rd_addr (frame_rd_addr),
    .frame_rd_data (frame_rd_data),
    .tbl_wr_en     (tbl_wr_en),
    .tbl_wr_addr   (tbl_wr_addr),
    .tbl_wr_data   (tbl_wr_data),
    .tbl_rd_addr   (tbl_rd_addr),
    .tbl_rd_data   (tbl_rd_data)
  );

  mbtrs_frame_mem #(
    .DEPTH (FRAME_BYTES)
  ) u_frame_mem (
    .clk     (clk),
    .wr_en   (frame_wr_en),
    .wr_addr (frame_wr_addr),
    .wr_data (frame_wr_data),
    .rd_addr (frame_rd_addr),
    .rd_data (frame_rd_data)
  );

  mbtrs_table_mem #(
    .DEPTH (REGISTERS)
  ) u_table_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr_data),
    .rd_addr (tbl_rd_addr),
    .rd_data (tbl_rd_data)
  );

endmodule

// ===== tb/sv/tb_modbus_tcp_register_server.sv =====
// Self-checking testbench for modbus_tcp_register_server: directed request table, then
// random request segments and local accesses under several register settings.
// Depends on mbtrs_pkg and the RTL top level only.
module tb_modbus_tcp_register_server;
  timeunit 1ns;
  timeprecision 1ps;

  import mbtrs_pkg::*;

  localparam int REGS = 8;
  localparam int FRAME = 32;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int SETTLE = 64;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 16;
  localparam logic [3:0] IN_CFG [PHASES] = '{4'd3, 4'd8, 4'd0, 4'd8, 4'd0, 4'd2};
  localparam logic [3:0] OUT_CFG [PHASES] = '{4'd5, 4'd0, 4'd8, 4'd8, 4'd0, 4'd6};

  typedef enum logic [2:0] {OP_FRAME, OP_ODD_COUNT, OP_LWRITE, OP_LREAD, OP_UNUSED} op_e;
  typedef enum logic [1:0] {CHK_MODEL, CHK_SILENT, CHK_VALUE} chk_e;

  typedef struct packed {
    op_e         op;
    logic [7:0]  fn;
    logic [15:0] proto;
    logic [15:0] first;
    logic [15:0] cnt;
    logic [8:0]  len;
    logic [2:0]  ix;
    logic [15:0] val;
    chk_e        chk;
    logic [15:0] want;
  } plan_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  tx_byte;
    logic [15:0] read_value;
    logic        last;
  } reply_t;

  localparam int NPLAN = 26;
  localparam plan_t PLAN [NPLAN] = '{
    '{OP_LREAD, 8'h00, 16'h0, 16'd0, 16'd0, 9'd0, 3'd0, 16'h0000, CHK_VALUE, 16'h0000},
    '{OP_LREAD, 8'h00, 16'h0, 16'd0, 16'd0, 9'd0, 3'd7, 16'h0000, CHK_VALUE, 16'h0000},
    '{OP_LWRITE, 8'h00, 16'h0, 16'd0, 16'd0, 9'd0, 3'd0, 16'h8000, CHK_SILENT, 16'h0000},
    '{OP_LWRITE, 8'h00, 16'h0, 16'd0, 16'd0, 9'd0, 3'd3, 16'h7FFF, CHK_SILENT, 16'h0000},
    '{OP_LWRITE, 8'h00, 16'h0, 16'd0, 16'd0, 9'd0, 3'd7, 16'hFFFF, CHK_SILENT, 16'h0000},
    '{OP_FRAME, FUNC_READ_HOLDING, 16'h0, 16'd0, 16'd4, 9'd0, 3'd0, 16'h0000, CHK_MODEL, 16'h0},
    '{OP_FRAME, FUNC_WRITE_MULTIPLE, 16'h0, 16'd4, 16'd4, 9'd0, 3'd0, 16'hFFFF, CHK_MODEL, 16'h0},
    '{OP_LREAD, 8'h00, 16'h0, 16'd0, 16'd0, 9'd0, 3'd0, 16'h0000, CHK_MODEL, 16'h0000},
    '{OP_LREAD, 8'h00, 16'h0, 16'd0, 16'd0, 9'd0, 3'd3, 16'h0000, CHK_MODEL, 16'h0000},
    '{OP_FRAME, FUNC_READ_HOLDING, 16'h0, 16'd0, 16'd8, 9'd0, 3'd0, 16'h1234, CHK_MODEL, 16'h0},
    '{OP_FRAME, FUNC_WRITE_MULTIPLE, 16'h0, 16'd7, 16'd1, 9'd0, 3'd0, 16'h0000, CHK_MODEL, 16'h0},
    '{OP_ODD_COUNT, FUNC_WRITE_MULTIPLE, 16'h0, 16'd0, 16'd2, 9'd0, 3'd0, 16'hA55A, CHK_MODEL,
      16'h0},
    '{OP_FRAME, FUNC_READ_HOLDING, 16'h0, 16'd8, 16'd1, 9'd0, 3'd0, 16'h0101, CHK_SILENT, 16'h0},
    '{OP_FRAME, FUNC_READ_HOLDING, 16'h0, 16'hFFFF, 16'd1, 9'd0, 3'd0, 16'h0202, CHK_SILENT,
      16'h0},
    '{OP_FRAME, FUNC_READ_HOLDING, 16'h0, 16'd0, 16'd0, 9'd0, 3'd0, 16'h0303, CHK_SILENT, 16'h0},
    '{OP_FRAME, FUNC_READ_HOLDING, 16'h0, 16'd0, 16'hFFFF, 9'd0, 3'd0, 16'h0404, CHK_SILENT,
      16'h0},
    '{OP_FRAME, FUNC_READ_HOLDING, 16'h0001, 16'd0, 16'd1, 9'd0, 3'd0, 16'h0505, CHK_SILENT,
      16'h0},
    '{OP_FRAME, FUNC_READ_HOLDING, 16'hFF00, 16'd0, 16'd1, 9'd0, 3'd0, 16'h0606, CHK_SILENT,
      16'h0},
    '{OP_FRAME, 8'h04, 16'h0, 16'd0, 16'd1, 9'd0, 3'd0, 16'h0707, CHK_SILENT, 16'h0},
    '{OP_FRAME, 8'hFF, 16'h0, 16'd0, 16'd1, 9'd0, 3'd0, 16'h0808, CHK_SILENT, 16'h0},
    '{OP_FRAME, FUNC_READ_HOLDING, 16'h0, 16'd0, 16'd1, 9'd11, 3'd0, 16'h0909, CHK_SILENT, 16'h0},
    '{OP_FRAME, FUNC_WRITE_MULTIPLE, 16'h0, 16'd0, 16'd2, 9'd16, 3'd0, 16'h0A0A, CHK_SILENT,
      16'h0},
    '{OP_FRAME, FUNC_WRITE_MULTIPLE, 16'h0, 16'd1, 16'd3, 9'd40, 3'd0, 16'h5AA5, CHK_MODEL, 16'h0},
    '{OP_FRAME, FUNC_READ_HOLDING, 16'h0, 16'd0, 16'd8, 9'd36, 3'd0, 16'hFEDC, CHK_MODEL, 16'h0},
    '{OP_UNUSED, 8'h00, 16'h0, 16'd0, 16'd0, 9'd0, 3'd5, 16'h1111, CHK_SILENT, 16'h0000},
    '{OP_LREAD, 8'h00, 16'h0, 16'd0, 16'd0, 9'd0, 3'd4, 16'h0000, CHK_VALUE, 16'h0000}
  };

  logic               clk;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_index = 1'b0;
  logic [3:0]         cfg_data = '0;
  logic               req_valid = 1'b0;
  logic               req_ready;
  logic [1:0]         cmd = '0;
  logic [7:0]         rx_byte = '0;
  logic               segment_end = 1'b0;
  logic [2:0]         local_index = '0;
  logic signed [15:0] local_value = '0;
  logic               rsp_valid;
  logic               rsp_ready = 1'b0;
  logic               kind;
  logic [7:0]         tx_byte;
  logic signed [15:0] read_value;
  logic               last;

  logic [15:0] held_regs [REGS];
  logic [7:0]  seg_bytes [FRAME];
  int unsigned seg_count;
  int unsigned in_regs;
  int unsigned read_regs;
  reply_t      reply_q [$];

  int unsigned items_sent;
  int unsigned frames_sent;
  int unsigned locals_sent;
  int unsigned replies_seen;
  int unsigned settings_used;
  int unsigned mismatches;
  int unsigned hold_left;
  bit          hold_start;
  bit          steady;

  modbus_tcp_register_server dut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("mismatch at %0t ns: %s", $time, what);
  endtask

  function automatic int unsigned table_span();
    int unsigned n;
    n = in_regs + read_regs;
    return (n > REGS) ? REGS : n;
  endfunction

  task automatic push_net(input logic [7:0] b, input logic fin);
    reply_q.push_back('{KIND_NET, b, 16'h0000, fin});
  endtask

  task automatic answer_segment();
    int unsigned fn, first, cnt, span, need, plen;
    logic [15:0] v;
    logic [7:0]  b;
    if (seg_count < MIN_FRAME_LEN || seg_bytes[2] != 8'h00 || seg_bytes[3] != 8'h00) return;
    fn = seg_bytes[7];
    first = {seg_bytes[8], seg_bytes[9]};
    cnt = {seg_bytes[10], seg_bytes[11]};
    span = table_span();
    if (cnt == 0 || first + cnt > span) return;
    if (fn == FUNC_READ_HOLDING) begin
      plen = 3 + 2 * cnt;
      for (int i = 0; i < 4; i++) push_net(seg_bytes[i], 1'b0);
      push_net(8'(plen >> 8), 1'b0);
      push_net(8'(plen), 1'b0);
      push_net(seg_bytes[6], 1'b0);
      push_net(FUNC_READ_HOLDING, 1'b0);
      push_net(8'(2 * cnt), 1'b0);
      for (int i = 0; i < cnt; i++) begin
        v = held_regs[first + i];
        push_net(v[15:8], 1'b0);
        push_net(v[7:0], i == cnt - 1);
      end
    end else if (fn == FUNC_WRITE_MULTIPLE) begin
      need = WRITE_DATA_START + 2 * cnt;
      if (seg_count < need || need > FRAME) return;
      for (int i = 0; i < cnt; i++) begin
        held_regs[first + i] = {seg_bytes[WRITE_DATA_START + 2 * i],
                                seg_bytes[WRITE_DATA_START + 1 + 2 * i]};
      end
      for (int i = 0; i < HDR_BYTES; i++) begin
        b = seg_bytes[i];
        if (i == 4) b = 8'h00;
        if (i == 5) b = ECHO_LENGTH;
        push_net(b, i == HDR_BYTES - 1);
      end
    end
  endtask

  task automatic serve_item(input logic [1:0] c, input logic [7:0] b, input logic fin,
                            input logic [2:0] ix, input logic [15:0] v);
    int unsigned pos;
    logic [15:0] got;
    case (c)
      CMD_NET_BYTE: begin
        if (seg_count < FRAME) seg_bytes[seg_count] = b;
        if (seg_count < BYTE_COUNT_MAX) seg_count++;
        if (fin) begin
          answer_segment();
          seg_count = 0;
        end
      end
      CMD_LOCAL_WRITE: begin
        if (ix < in_regs && ix < REGS) held_regs[ix] = v;
      end
      CMD_LOCAL_READ: begin
        pos = in_regs + ix;
        got = 16'h0000;
        if (ix < read_regs && pos < table_span()) got = held_regs[pos];
        reply_q.push_back('{KIND_LOCAL, 8'h00, got, 1'b1});
      end
      default: ;
    endcase
  endtask

  task automatic send_req(input logic [1:0] c, input logic [7:0] b, input logic fin,
                          input logic [2:0] ix, input logic [15:0] v, input bit emit);
    int unsigned mark;
    while (!steady && $urandom_range(0, 99) < 34) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    cmd <= c;
    rx_byte <= b;
    segment_end <= fin;
    local_index <= ix;
    local_value <= v;
    do @(posedge clk); while (!req_ready);
    mark = reply_q.size();
    serve_item(c, b, fin, ix, v);
    if (!emit) while (reply_q.size() > mark) void'(reply_q.pop_back());
    if (c != CMD_UNUSED) items_sent++;
    if (c == CMD_LOCAL_WRITE || c == CMD_LOCAL_READ) locals_sent++;
  endtask

  task automatic send_frame(input logic [7:0] fn, input logic [15:0] proto,
                            input logic [15:0] first, input logic [15:0] cnt, input int len,
                            input bit odd_count, input bit emit, input logic [15:0] seed);
    logic [7:0]  seg [$];
    logic [15:0] mlen, word;
    int          nwords;
    mlen = (fn == FUNC_WRITE_MULTIPLE) ? 16'(7 + 2 * cnt) : 16'd6;
    seg.push_back(seed[15:8]);
    seg.push_back(seed[7:0]);
    seg.push_back(proto[15:8]);
    seg.push_back(proto[7:0]);
    seg.push_back(mlen[15:8]);
    seg.push_back(mlen[7:0]);
    seg.push_back(seed[7:0] ^ 8'h5A);
    seg.push_back(fn);
    seg.push_back(first[15:8]);
    seg.push_back(first[7:0]);
    seg.push_back(cnt[15:8]);
    seg.push_back(cnt[7:0]);
    if (fn == FUNC_WRITE_MULTIPLE) begin
      seg.push_back(odd_count ? 8'hFF : 8'(2 * cnt));
      nwords = (cnt > REGS) ? REGS : cnt;
      for (int i = 0; i < nwords; i++) begin
        word = seed ^ 16'(i * 16'h9E37);
        seg.push_back(word[15:8]);
        seg.push_back(word[7:0]);
      end
    end
    if (len > 0) begin
      while (seg.size() > len) void'(seg.pop_back());
      while (seg.size() < len) seg.push_back(8'($urandom));
    end
    frames_sent++;
    foreach (seg[i]) begin
      send_req(CMD_NET_BYTE, seg[i], i == seg.size() - 1, 3'($urandom), 16'($urandom), emit);
    end
  endtask

  task automatic random_frame();
    int unsigned span, cnt, first, len, pick;
    logic [7:0]  fn;
    logic [15:0] proto;
    bit          odd;
    span = table_span();
    fn = $urandom_range(0, 1) ? FUNC_READ_HOLDING : FUNC_WRITE_MULTIPLE;
    cnt = (span == 0) ? 1 : $urandom_range(1, span);
    first = (span >= cnt) ? $urandom_range(0, span - cnt) : 0;
    proto = 16'h0000;
    len = 0;
    odd = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 99) >= 78) begin
      pick = $urandom_range(0, 6);
      case (pick)
        0: proto = 16'($urandom_range(1, 16'hFFFF));
        1: cnt = 0;
        2: first = $urandom_range(span - cnt + 1, 16'hFFFF);
        3: do fn = 8'($urandom); while (fn == FUNC_READ_HOLDING || fn == FUNC_WRITE_MULTIPLE);
        4: len = $urandom_range(1, MIN_FRAME_LEN - 1);
        5: begin
          fn = FUNC_WRITE_MULTIPLE;
          len = $urandom_range(MIN_FRAME_LEN, MIN_FRAME_LEN + 2 * cnt);
        end
        default: begin
          len = MIN_FRAME_LEN + $urandom_range(1, 40);
          if (fn == FUNC_WRITE_MULTIPLE) len += 1 + 2 * cnt;
        end
      endcase
    end
    send_frame(fn, proto, 16'(first), 16'(cnt), len, odd, 1'b1, 16'($urandom));
  endtask

  task automatic random_item();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      random_frame();
    end else if (pick < 77) begin
      send_req(CMD_LOCAL_WRITE, 8'($urandom), 1'($urandom), 3'($urandom), 16'($urandom), 1'b1);
    end else if (pick < 96) begin
      send_req(CMD_LOCAL_READ, 8'($urandom), 1'($urandom), 3'($urandom), 16'($urandom), 1'b1);
    end else begin
      send_req(CMD_UNUSED, 8'($urandom), 1'($urandom), 3'($urandom), 16'($urandom), 1'b1);
    end
  endtask

  task automatic write_reg(input logic ix, input logic [3:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= ix;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    if (ix == CFG_INPUT_COUNT) in_regs = v;
    else read_regs = v;
  endtask

  task automatic set_config(input logic [3:0] ins, input logic [3:0] outs);
    write_reg(CFG_INPUT_COUNT, ins);
    write_reg(CFG_OUTPUT_COUNT, outs);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic wait_idle();
    while (reply_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic take_reply();
    reply_t w;
    string  diffs;
    replies_seen++;
    if (reply_q.size() == 0) begin
      flag_mismatch($sformatf("transfer with nothing pending: kind %0d byte %02h value %0d",
                              kind, tx_byte, read_value));
      return;
    end
    w = reply_q.pop_front();
    diffs = "";
    if (kind !== w.kind) diffs = {diffs, $sformatf(" kind %0d want %0d", kind, w.kind)};
    if (tx_byte !== w.tx_byte)
      diffs = {diffs, $sformatf(" tx_byte %02h want %02h", tx_byte, w.tx_byte)};
    if (read_value !== w.read_value)
      diffs = {diffs, $sformatf(" read_value %04h want %04h", read_value, w.read_value)};
    if (last !== w.last) diffs = {diffs, $sformatf(" last %0d want %0d", last, w.last)};
    if (diffs != "") flag_mismatch($sformatf("transfer %0d:%s", replies_seen, diffs));
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && rsp_ready) take_reply();
      if (hold_start) begin
        hold_start = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= steady || ($urandom_range(0, 99) >= 34);
      end
    end
  end

  initial begin
    int unsigned goal;
    foreach (held_regs[i]) held_regs[i] = 16'h0000;
    foreach (seg_bytes[i]) seg_bytes[i] = 8'h00;
    seg_count = 0;
    in_regs = COUNT_RESET;
    read_regs = COUNT_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_config(COUNT_RESET, COUNT_RESET);

    foreach (PLAN[i]) begin
      case (PLAN[i].op)
        OP_FRAME, OP_ODD_COUNT: begin
          send_frame(PLAN[i].fn, PLAN[i].proto, PLAN[i].first, PLAN[i].cnt, PLAN[i].len,
                     PLAN[i].op == OP_ODD_COUNT, PLAN[i].chk == CHK_MODEL, PLAN[i].val);
        end
        OP_LWRITE: begin
          send_req(CMD_LOCAL_WRITE, 8'h00, 1'b0, PLAN[i].ix, PLAN[i].val,
                   PLAN[i].chk == CHK_MODEL);
        end
        OP_LREAD: begin
          send_req(CMD_LOCAL_READ, 8'hFF, 1'b1, PLAN[i].ix, PLAN[i].val,
                   PLAN[i].chk == CHK_MODEL);
        end
        default: begin
          send_req(CMD_UNUSED, 8'hFF, 1'b1, PLAN[i].ix, PLAN[i].val, 1'b0);
        end
      endcase
      if (PLAN[i].chk == CHK_VALUE) reply_q.push_back('{KIND_LOCAL, 8'h00, PLAN[i].want, 1'b1});
    end
    req_valid <= 1'b0;
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      set_config(IN_CFG[p], OUT_CFG[p]);
      steady = (p == 2);
      if (p == 0) hold_start = 1'b1;
      goal = items_sent + ITEMS_PER_PHASE;
      while (items_sent < goal) random_item();
      req_valid <= 1'b0;
      wait_idle();
    end

    $display("Run covered %0d request segments and %0d local accesses over %0d settings.",
             frames_sent, locals_sent, settings_used);
    $display("%0d output transfers were checked; %0d mismatches.", replies_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
